@@ rtl/fac_pkg.sv @@
// Shared types, constants and helper functions for the Fuzzy ART category scorer.
package fac_pkg;

	localparam int VAL_W = 17;
	localparam int FRAC_W = 16;
	localparam int ACC_W = 23;
	localparam int TOPO_W = 23;
	localparam int DIM_W = 7;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_W;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;
	localparam logic [TOPO_W-1:0] TOPO_MAX = '1;

	localparam logic [VAL_W-1:0] ALPHA_RST = VAL_W'(66);
	localparam logic [VAL_W-1:0] BETA_RST = ONE_Q;
	localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(1);

	typedef enum logic [1:0] {
		REG_ALPHA = 2'd0,
		REG_BETA  = 2'd1,
		REG_DIM   = 2'd2
	} reg_idx_t;

	typedef enum logic {
		BK_IDLE,
		BK_DIV
	} back_state_t;

	// One element on its way from the front part to the back part. The sums are
	// only meaningful on the last element of a vector.
	typedef struct packed {
		logic [VAL_W-1:0] nw;
		logic             nw_missing;
		logic             last;
		logic [ACC_W-1:0] smin;
		logic [ACC_W-1:0] sw;
		logic [ACC_W-1:0] sx;
		logic [ACC_W-1:0] sdef;
	} q_entry_t;

	function automatic logic [VAL_W-1:0] clamp_one(input logic [VAL_W-1:0] v);
		return (v > ONE_Q) ? ONE_Q : v;
	endfunction

	function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] acc,
		input logic [VAL_W-1:0] v);
		logic [ACC_W:0] s;
		s = {1'b0, acc} + (ACC_W+1)'(v);
		return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
	endfunction

endpackage

@@ rtl/fuzzy_art_category_score.sv @@
// Top level of the Fuzzy ART category scorer: configuration registers, front, queue and back.
// One element pair is accepted per cycle while the queue is not full, and its learned weight
// leaves one result per element. An element that is not the last of its vector is loaded
// straight into the output register, so a stream of such elements runs at one item per cycle
// while the output is not stalled. The last element of a vector holds the back part until
// the 23-step bit-serial division of the deficit sum by the dimension and the two 16-step ratio
// dividers are done; meanwhile the queue of QUEUE_DEPTH entries takes elements until it fills.
module fuzzy_art_category_score
	import fac_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [VAL_W-1:0]  x_value,
	input  logic              x_missing,
	input  logic [VAL_W-1:0]  w_value,
	input  logic              w_missing,
	input  logic              last_element,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VAL_W-1:0]  new_weight,
	output logic              new_weight_missing,
	output logic              is_last,
	output logic [VAL_W-1:0]  choice_score,
	output logic [VAL_W-1:0]  match_score,
	output logic [TOPO_W-1:0] topo_score,
	output logic              divide_fault
);

	logic [VAL_W-1:0] alpha_q, beta_q;
	logic [DIM_W-1:0] dim_q;
	reg_idx_t         reg_idx;
	logic             wr_en;

	logic     q_push, q_pop, q_full, q_empty;
	q_entry_t q_in, q_head;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			beta_q <= BETA_RST;
			dim_q <= DIM_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ALPHA: alpha_q <= pwdata[VAL_W-1:0];
				REG_BETA:  beta_q <= pwdata[VAL_W-1:0];
				REG_DIM:   dim_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ALPHA: prdata = DATA_W'(alpha_q);
			REG_BETA:  prdata = DATA_W'(beta_q);
			REG_DIM:   prdata = DATA_W'(dim_q);
			default:   prdata = '0;
		endcase
	end

	fac_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.x_value      (x_value),
		.x_missing    (x_missing),
		.w_value      (w_value),
		.w_missing    (w_missing),
		.last_element (last_element),
		.beta         (clamp_one(beta_q)),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_in)
	);

	fac_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	fac_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.alpha              (clamp_one(alpha_q)),
		.dim                (dim_q),
		.head               (q_head),
		.q_empty            (q_empty),
		.q_pop              (q_pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.new_weight         (new_weight),
		.new_weight_missing (new_weight_missing),
		.is_last            (is_last),
		.choice_score       (choice_score),
		.match_score        (match_score),
		.topo_score         (topo_score),
		.divide_fault       (divide_fault)
	);

endmodule

@@ rtl/fac_queue.sv @@
// Small register queue that decouples the element front part from the back part.
module fac_queue
	import fac_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output q_entry_t head,
	output logic     empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

@@ rtl/fac_front.sv @@
// Front: takes one element pair a cycle unless stalled, learns weights, keeps vector sums.
module fac_front
	import fac_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [VAL_W-1:0] x_value,
	input  logic             x_missing,
	input  logic [VAL_W-1:0] w_value,
	input  logic             w_missing,
	input  logic             last_element,
	input  logic [VAL_W-1:0] beta,
	input  logic             q_full,
	output logic             q_push,
	output q_entry_t         q_entry
);

	localparam int PROD_W = 2 * VAL_W;

	logic [ACC_W-1:0]  smin_q, sw_q, sx_q, sdef_q;
	logic [ACC_W-1:0]  smin_nx, sw_nx, sx_nx, sdef_nx;
	logic [VAL_W-1:0]  x_c, w_c, m, diff;
	logic [PROD_W-1:0] prod, blend;
	logic              both;

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		x_c = clamp_one(x_value);
		w_c = clamp_one(w_value);
		m = (x_c < w_c) ? x_c : w_c;
		diff = w_c - m;
		both = !x_missing && !w_missing;
		// beta*m + (1-beta)*w rewritten as w - beta*(w-m), which needs one multiplier.
		prod = PROD_W'(beta) * PROD_W'(diff);
		blend = (PROD_W'(w_c) << FRAC_W) - prod;

		sx_nx = x_missing ? sx_q : sat_acc(sx_q, x_c);
		sw_nx = w_missing ? sw_q : sat_acc(sw_q, w_c);
		smin_nx = both ? sat_acc(smin_q, m) : smin_q;
		sdef_nx = both ? sat_acc(sdef_q, diff) : sdef_q;

		q_entry.nw = both ? blend[FRAC_W +: VAL_W] : '0;
		q_entry.nw_missing = !both;
		q_entry.last = last_element;
		q_entry.smin = smin_nx;
		q_entry.sw = sw_nx;
		q_entry.sx = sx_nx;
		q_entry.sdef = sdef_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smin_q <= '0;
			sw_q <= '0;
			sx_q <= '0;
			sdef_q <= '0;
		end else if (q_push) begin
			if (last_element) begin
				smin_q <= '0;
				sw_q <= '0;
				sx_q <= '0;
				sdef_q <= '0;
			end else begin
				smin_q <= smin_nx;
				sw_q <= sw_nx;
				sx_q <= sx_nx;
				sdef_q <= sdef_nx;
			end
		end
	end

endmodule

@@ rtl/fac_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module fac_div
	import fac_pkg::*;
#(
	parameter int DEN_W = ACC_W,
	parameter int STEPS = FRAC_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEN_W-1:0] rem_init,
	input  logic [STEPS-1:0] dividend,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [STEPS-1:0] quot
);

	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [STEPS-1:0] dvd_q, quot_q;
	logic [DEN_W:0]   trial, diff;
	logic             ge;

	assign busy = busy_q;
	assign quot = quot_q;

	always_comb begin
		trial = {rem_q, dvd_q[STEPS-1]};
		diff = trial - {1'b0, den_q};
		ge = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			dvd_q <= dvd_q << 1;
			quot_q <= {quot_q[STEPS-2:0], ge};
		end
	end

endmodule

@@ rtl/fac_back.sv @@
// Back part: passes element results on and computes the vector scores on the last element.
module fac_back
	import fac_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [VAL_W-1:0]  alpha,
	input  logic [DIM_W-1:0]  dim,
	input  q_entry_t          head,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VAL_W-1:0]  new_weight,
	output logic              new_weight_missing,
	output logic              is_last,
	output logic [VAL_W-1:0]  choice_score,
	output logic [VAL_W-1:0]  match_score,
	output logic [TOPO_W-1:0] topo_score,
	output logic              divide_fault
);

	localparam int CDEN_W = ACC_W + 1;

	back_state_t state_q, state_nx;

	logic              out_valid_q;
	logic [VAL_W-1:0]  nw_q, choice_q, match_q;
	logic              nwm_q, last_q, fault_q;
	logic [TOPO_W-1:0] topo_q;

	logic              out_free, start, load;
	logic [CDEN_W-1:0] cden;
	logic              c_busy, m_busy, t_busy;
	logic [FRAC_W-1:0] c_quot, m_quot;
	logic [ACC_W-1:0]  t_quot;
	logic [VAL_W-1:0]  choice_v, match_v;
	logic [TOPO_W-1:0] topo_v;
	logic [TOPO_W:0]   topo_sum;
	logic              fault_v;

	assign out_free = !out_valid_q || !out_stall;
	assign cden = {1'b0, head.sw} + CDEN_W'(alpha);

	fac_div #(.DEN_W(CDEN_W), .STEPS(FRAC_W)) u_div_choice (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.rem_init ({1'b0, head.smin}),
		.dividend ('0),
		.den      (cden),
		.busy     (c_busy),
		.quot     (c_quot)
	);

	fac_div #(.DEN_W(ACC_W), .STEPS(FRAC_W)) u_div_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.rem_init (head.smin),
		.dividend ('0),
		.den      (head.sx),
		.busy     (m_busy),
		.quot     (m_quot)
	);

	fac_div #(.DEN_W(DIM_W), .STEPS(ACC_W)) u_div_topo (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.rem_init ('0),
		.dividend (head.sdef),
		.den      (dim),
		.busy     (t_busy),
		.quot     (t_quot)
	);

	// Score assembly. A numerator at or above the divisor gives a ratio clamped to one.
	always_comb begin
		fault_v = 1'b0;
		if (cden == '0) begin
			choice_v = '0;
			fault_v = 1'b1;
		end else if (CDEN_W'(head.smin) >= cden)
			choice_v = ONE_Q;
		else
			choice_v = VAL_W'(c_quot);

		if (head.sx == '0) begin
			match_v = '0;
			fault_v = 1'b1;
		end else if (head.smin >= head.sx)
			match_v = ONE_Q;
		else
			match_v = VAL_W'(m_quot);

		topo_sum = (TOPO_W+1)'(ONE_Q) + (TOPO_W+1)'(t_quot);
		if (dim == '0) begin
			topo_v = '0;
			fault_v = 1'b1;
		end else if (topo_sum[TOPO_W])
			topo_v = TOPO_MAX;
		else
			topo_v = topo_sum[TOPO_W-1:0];
	end

	always_comb begin
		state_nx = state_q;
		start = 1'b0;
		load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					if (head.last) begin
						start = 1'b1;
						state_nx = BK_DIV;
					end else if (out_free) begin
						load = 1'b1;
					end
				end
			end
			BK_DIV: begin
				if (!c_busy && !m_busy && !t_busy && out_free) begin
					load = 1'b1;
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nw_q <= head.nw;
			nwm_q <= head.nw_missing;
			last_q <= head.last;
			choice_q <= head.last ? choice_v : '0;
			match_q <= head.last ? match_v : '0;
			topo_q <= head.last ? topo_v : '0;
			fault_q <= head.last && fault_v;
		end
	end

	assign out_valid = out_valid_q;
	assign new_weight = nw_q;
	assign new_weight_missing = nwm_q;
	assign is_last = last_q;
	assign choice_score = choice_q;
	assign match_score = match_q;
	assign topo_score = topo_q;
	assign divide_fault = fault_q;

endmodule
